// ----- hw/rtl/qyd_pkg.sv -----
package qyd_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 12;

    localparam int TICKS_W = 13;
    localparam int SCALE_W = 16;
    localparam int ANGLE_W = 12;
    localparam int STEP_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 13'd448;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd52662;

    // register index, taken from the word address
    localparam logic REG_TICKS_PER_REV = 1'b0;
    localparam logic REG_DEGREES_SCALE = 1'b1;

    // step codes, two's complement
    localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
    localparam logic signed [STEP_W-1:0] STEP_FWD  = 2'sb01;
    localparam logic signed [STEP_W-1:0] STEP_BACK = 2'sb11;

    // x4 decode: index is {old_a, old_b, new_a, new_b}
    function automatic logic signed [STEP_W-1:0] step_lookup(input logic [3:0] idx);
        logic signed [STEP_W-1:0] s;
        unique case (idx)
            4'h1, 4'h7, 4'h8, 4'he: s = STEP_FWD;
            4'h2, 4'h4, 4'hb, 4'hd: s = STEP_BACK;
            default:                s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/qyd_wrap.sv -----
module qyd_wrap #(
    parameter int POSITION_WIDTH = qyd_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic [POSITION_WIDTH-1:0]          i_position,
    input  logic [qyd_pkg::TICKS_W-1:0]        i_ticks_per_rev,
    input  logic signed [qyd_pkg::STEP_W-1:0]  i_step,
    input  logic                               i_ref_zero,
    output logic [POSITION_WIDTH-1:0]          o_position
);

    localparam int MOD_W = (POSITION_WIDTH + 1 > qyd_pkg::TICKS_W) ?
                           POSITION_WIDTH + 1 : qyd_pkg::TICKS_W;

    logic [MOD_W-1:0] ticks_ext;
    logic [MOD_W-1:0] limit;
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] pos_ext;
    logic [MOD_W-1:0] sum;
    logic [MOD_W-1:0] wrapped;
    logic             fwd;
    logic             back;

    assign ticks_ext = MOD_W'(i_ticks_per_rev);
    assign limit     = MOD_W'(1) << POSITION_WIDTH;
    assign pos_ext   = MOD_W'(i_position);
    assign fwd       = (i_step == qyd_pkg::STEP_FWD);
    assign back      = (i_step == qyd_pkg::STEP_BACK);

    always_comb begin
        // saturate to the counter range, and treat zero as one
        if (ticks_ext > limit) begin
            modulus = limit;
        end else if (ticks_ext == '0) begin
            modulus = MOD_W'(1);
        end else begin
            modulus = ticks_ext;
        end
    end

    assign sum = pos_ext + MOD_W'(fwd) - MOD_W'(back);

    always_comb begin
        priority if (back && (pos_ext == '0)) begin
            wrapped = modulus - MOD_W'(1);
        end else if (sum >= modulus) begin
            wrapped = '0;
        end else begin
            wrapped = sum;
        end
    end

    assign o_position = i_ref_zero ? '0 : wrapped[POSITION_WIDTH-1:0];

endmodule

// ----- hw/rtl/quadrature_yaw_decoder_core.sv -----
// Quadrature yaw decoder, x4 decoding with a wrapping tick position.
// Input channel: one request per sample of encoder phases A and B plus the
//   reference flag, moved when i_in_valid is high and o_in_stall is low.
// Output channel: one request per input request carrying the position, the
//   step (-1, 0, +1) and the angle in whole degrees, moved when o_out_valid
//   is high and i_out_stall is low.
// Pipeline: stage one, then stage two, the output register that drives o_out_valid.
//   Throughput: one request per cycle while i_out_stall is low; stage one runs
//   the decode table and the wrap compare, stage two the 16x16 angle multiply.
// Stall: when the receiver stalls, the output register holds; a request in
//   stage one waits behind it, and o_in_stall rises only when both stages
//   are full.
// Reset (synchronous, i_rst_n low): both stages empty, phase history and
//   position cleared to zero, registers back to 448 ticks and 52662 scale.
// Configuration: APB, ticks_per_rev at 0x0, degrees_scale at 0x4; write only
//   while the pipeline is empty.
module quadrature_yaw_decoder_core #(
    parameter int POSITION_WIDTH = qyd_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_phase_a,
    input  logic                                i_phase_b,
    input  logic                                i_ref_zero,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [POSITION_WIDTH-1:0]           o_position,
    output logic signed [qyd_pkg::STEP_W-1:0]   o_step,
    output logic [qyd_pkg::ANGLE_W-1:0]         o_angle_deg,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qyd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [qyd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [qyd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int PROD_W = 2 * qyd_pkg::SCALE_W;

    // configuration registers
    logic [qyd_pkg::TICKS_W-1:0] r_ticks_per_rev;
    logic [qyd_pkg::SCALE_W-1:0] r_degrees_scale;
    logic                        cfg_write;
    logic                        cfg_index;

    // decoder state; r_tick_position doubles as the stage-one position
    logic                         r_last_a;
    logic                         r_last_b;
    logic [POSITION_WIDTH-1:0]    r_tick_position;
    logic [POSITION_WIDTH-1:0]    n_tick_position;

    // stage one
    logic                             r_s1_valid;
    logic signed [qyd_pkg::STEP_W-1:0] r_s1_step;
    logic signed [qyd_pkg::STEP_W-1:0] n_step;

    // stage two, the output register
    logic                              r_out_valid;
    logic [POSITION_WIDTH-1:0]         r_out_position;
    logic signed [qyd_pkg::STEP_W-1:0] r_out_step;
    logic [qyd_pkg::ANGLE_W-1:0]       r_out_angle;
    logic [PROD_W-1:0]                 product;

    logic adv_out;
    logic adv_s1;
    logic in_accept;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_rev <= qyd_pkg::TICKS_RESET;
            r_degrees_scale <= qyd_pkg::SCALE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                qyd_pkg::REG_TICKS_PER_REV: r_ticks_per_rev <= pwdata[qyd_pkg::TICKS_W-1:0];
                qyd_pkg::REG_DEGREES_SCALE: r_degrees_scale <= pwdata[qyd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            qyd_pkg::REG_TICKS_PER_REV: prdata = qyd_pkg::APB_DATA_W'(r_ticks_per_rev);
            qyd_pkg::REG_DEGREES_SCALE: prdata = qyd_pkg::APB_DATA_W'(r_degrees_scale);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- pipeline flow ----------------
    // advance the output register whenever it is empty or being drained;
    // stage one moves whenever the output register can take its request
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_s1     = !r_s1_valid || adv_out;
    assign o_in_stall = !adv_s1;
    assign in_accept  = i_in_valid && adv_s1;

    // ---------------- stage one: decode and wrap ----------------
    assign n_step = qyd_pkg::step_lookup({r_last_a, r_last_b, i_phase_a, i_phase_b});

    qyd_wrap #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_wrap (
        .i_position      (r_tick_position),
        .i_ticks_per_rev (r_ticks_per_rev),
        .i_step          (n_step),
        .i_ref_zero      (i_ref_zero),
        .o_position      (n_tick_position)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_last_a        <= 1'b0;
            r_last_b        <= 1'b0;
            r_tick_position <= '0;
        end else if (adv_s1) begin
            r_s1_valid <= i_in_valid;
            if (i_in_valid) begin
                r_last_a        <= i_phase_a;
                r_last_b        <= i_phase_b;
                r_tick_position <= n_tick_position;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_step <= n_step;
        end
    end

    // ---------------- stage two: angle multiply ----------------
    // whole degrees are the integer part of the 16.16 product
    assign product = qyd_pkg::SCALE_W'(r_tick_position) * r_degrees_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_position <= r_tick_position;
            r_out_step     <= r_s1_step;
            r_out_angle    <= product[qyd_pkg::FRAC_W +: qyd_pkg::ANGLE_W];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_position;
    assign o_step      = r_out_step;
    assign o_angle_deg = r_out_angle;

`ifndef NO_ASSERTIONS
    // a reference mark leaves the position at zero
    a_ref_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_ref_zero |=> r_tick_position == '0)
        else $error("position not cleared by reference mark");

    // a stage-one request held behind a stalled output is not lost
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !adv_out |=> r_s1_valid && $stable(r_tick_position))
        else $error("stage one dropped a request under stall");

    // input stalls only when both stages are full and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // the decode table never yields the unused step code
    a_step_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> r_s1_step != 2'sb10)
        else $error("illegal step code in stage one");

    // a stage-one request reaches the output register on the next edge
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && adv_out |=> r_out_valid)
        else $error("stage one request missed the output register");
`endif

endmodule
